/* rtl/c2i_pkg.sv */
`default_nettype none

package c2i_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic [1:0] STATUS_OK            = 2'd0;
    localparam logic [1:0] STATUS_NOT_CANONICAL = 2'd1;
    localparam logic [1:0] STATUS_OUT_OF_RANGE  = 2'd2;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_DIGIT = 2'd1,
        KIND_MINUS = 2'd2,
        KIND_OTHER = 2'd3
    } char_kind_t;

    typedef struct packed {
        logic       func;
        logic [7:0] character;
        logic       no_char;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic [63:0] parsed_value;
        logic [1:0]  status;
    } out_word_t;

    typedef struct packed {
        logic       func;
        char_kind_t kind;
        logic [3:0] digit;
        logic       last;
    } entry_t;

    typedef struct packed {
        logic        func;
        logic [63:0] magnitude;
        logic        overflowed;
        logic        negative;
        logic [1:0]  digits_seen;
        logic        first_digit_zero;
        logic        format_bad;
    } snap_t;

endpackage

`default_nettype wire

/* rtl/c2i_front.sv */
`default_nettype none

module c2i_front
    import c2i_pkg::*;
(
    input  in_word_t in_data,
    output entry_t   entry
);

    logic       is_digit;
    logic [7:0] offset;

    assign offset   = in_data.character - CHAR_ZERO;
    assign is_digit = (in_data.character >= CHAR_ZERO) && (in_data.character <= CHAR_NINE);

    always_comb
    begin
        entry.func  = in_data.func;
        entry.last  = in_data.last;
        entry.digit = is_digit ? offset[3:0] : 4'd0;
        priority if (in_data.no_char)
        begin
            entry.kind = KIND_NONE;
        end
        else if (is_digit)
        begin
            entry.kind = KIND_DIGIT;
        end
        else if (in_data.character == CHAR_MINUS)
        begin
            entry.kind = KIND_MINUS;
        end
        else
        begin
            entry.kind = KIND_OTHER;
        end
    end

endmodule

`default_nettype wire

/* rtl/c2i_queue.sv */
`default_nettype none

module c2i_queue
    import c2i_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output entry_t head
);

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/c2i_back.sv */
`default_nettype none

module c2i_back
    import c2i_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  entry_t    q_entry,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);

    logic [63:0] mag_reg;
    logic [63:0] mag_next;
    logic        ovf_reg;
    logic        ovf_next;
    logic        neg_reg;
    logic        neg_next;
    logic [1:0]  dseen_reg;
    logic [1:0]  dseen_next;
    logic        fzero_reg;
    logic        fzero_next;
    logic        bad_reg;
    logic        bad_next;

    logic        t_ovf;
    logic        t_neg;
    logic [1:0]  t_dseen;
    logic        t_fzero;
    logic        t_bad;
    logic [67:0] scaled;
    logic        at_start;
    logic        take;

    snap_t       snap_reg;
    logic        snap_valid_reg;
    logic        snap_valid_next;
    logic        snap_ready;

    logic        out_valid_reg;
    logic        out_valid_next;
    out_word_t   out_data_reg;
    out_word_t   fin_word;
    logic        out_take;
    logic        fin_bad;
    logic        fin_over;

    assign out_take   = !out_valid_reg || !out_stall;
    assign snap_ready = !snap_valid_reg || out_take;
    assign take       = q_valid && (!q_entry.last || snap_ready);
    assign q_pop      = take;

    assign scaled   = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1) + {64'b0, q_entry.digit};
    assign at_start = (dseen_reg == 2'd0) && !neg_reg && !bad_reg;

    always_comb
    begin
        t_ovf   = ovf_reg;
        t_neg   = neg_reg;
        t_dseen = dseen_reg;
        t_fzero = fzero_reg;
        t_bad   = bad_reg;
        unique case (q_entry.kind)
            KIND_DIGIT:
            begin
                if (dseen_reg == 2'd0)
                begin
                    t_fzero = fzero_reg || (q_entry.digit == 4'd0);
                end
                else if (fzero_reg)
                begin
                    t_bad = 1'b1;
                end
                if (dseen_reg != 2'd3)
                begin
                    t_dseen = dseen_reg + 1'b1;
                end
                t_ovf = ovf_reg || (scaled[67:64] != 4'd0);
            end
            KIND_MINUS:
            begin
                if (q_entry.func && at_start)
                begin
                    t_neg = 1'b1;
                end
                else
                begin
                    t_bad = 1'b1;
                end
            end
            KIND_OTHER:
            begin
                t_bad = 1'b1;
            end
            default:
            begin
                t_bad = bad_reg;
            end
        endcase
    end

    always_comb
    begin
        mag_next   = mag_reg;
        ovf_next   = ovf_reg;
        neg_next   = neg_reg;
        dseen_next = dseen_reg;
        fzero_next = fzero_reg;
        bad_next   = bad_reg;
        if (take)
        begin
            if (q_entry.last)
            begin
                mag_next   = '0;
                ovf_next   = 1'b0;
                neg_next   = 1'b0;
                dseen_next = 2'd0;
                fzero_next = 1'b0;
                bad_next   = 1'b0;
            end
            else
            begin
                mag_next   = (q_entry.kind == KIND_DIGIT) ? scaled[63:0] : mag_reg;
                ovf_next   = t_ovf;
                neg_next   = t_neg;
                dseen_next = t_dseen;
                fzero_next = t_fzero;
                bad_next   = t_bad;
            end
        end
    end

    always_comb
    begin
        if (take && q_entry.last)
        begin
            snap_valid_next = 1'b1;
        end
        else if (out_take)
        begin
            snap_valid_next = 1'b0;
        end
        else
        begin
            snap_valid_next = snap_valid_reg;
        end
        out_valid_next = out_take ? snap_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg        <= '0;
            ovf_reg        <= 1'b0;
            neg_reg        <= 1'b0;
            dseen_reg      <= 2'd0;
            fzero_reg      <= 1'b0;
            bad_reg        <= 1'b0;
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mag_reg        <= mag_next;
            ovf_reg        <= ovf_next;
            neg_reg        <= neg_next;
            dseen_reg      <= dseen_next;
            fzero_reg      <= fzero_next;
            bad_reg        <= bad_next;
            snap_valid_reg <= snap_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // The closing stage judges format first, then range, and negates the magnitude.
    always_comb
    begin
        fin_bad = snap_reg.format_bad || (snap_reg.digits_seen == 2'd0)
                  || (snap_reg.negative && snap_reg.first_digit_zero
                      && (snap_reg.digits_seen == 2'd1))
                  || (snap_reg.negative && !snap_reg.func);
        if (!snap_reg.func)
        begin
            fin_over = snap_reg.overflowed;
        end
        else if (snap_reg.negative)
        begin
            fin_over = snap_reg.overflowed
                       || (snap_reg.magnitude[63] && (snap_reg.magnitude[62:0] != '0));
        end
        else
        begin
            fin_over = snap_reg.overflowed || snap_reg.magnitude[63];
        end
        priority if (fin_bad)
        begin
            fin_word.status       = STATUS_NOT_CANONICAL;
            fin_word.parsed_value = '0;
        end
        else if (fin_over)
        begin
            fin_word.status       = STATUS_OUT_OF_RANGE;
            fin_word.parsed_value = '0;
        end
        else
        begin
            fin_word.status       = STATUS_OK;
            fin_word.parsed_value = snap_reg.negative ? (64'd0 - snap_reg.magnitude)
                                                      : snap_reg.magnitude;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && q_entry.last)
        begin
            snap_reg.func             <= q_entry.func;
            snap_reg.magnitude        <= (q_entry.kind == KIND_DIGIT) ? scaled[63:0] : mag_reg;
            snap_reg.overflowed       <= t_ovf;
            snap_reg.negative         <= t_neg;
            snap_reg.digits_seen      <= t_dseen;
            snap_reg.first_digit_zero <= t_fzero;
            snap_reg.format_bad       <= t_bad;
        end
        if (out_take && snap_valid_reg)
        begin
            out_data_reg <= fin_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

/* rtl/canonical_decimal_to_int64_top.sv */
// Channel | Handshake          | Word        | Contents
// in      | in_valid, in_stall | in_data     | func, character, no_char, last
// out     | out_valid, out_stall | out_data  | parsed_value, status
//
// One character word is taken every cycle while the two-entry queue has room.
// After its last word is taken, a result passes the queue, the accumulator
// with its multiply-by-ten add, then the closing stage that judges and negates.
// Reset clears the accumulator and all valid flags; no clearing pass is needed.
// A stall on the output backs up into the queue, and in_stall rises only when
// the queue is full.
`default_nettype none

module canonical_decimal_to_int64_top
    import c2i_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);

    entry_t front_entry;
    entry_t q_head;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;

    c2i_front u_front (
        .in_data (in_data),
        .entry   (front_entry)
    );

    c2i_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    c2i_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign in_stall = q_full;

    a_full_has_head : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_valid)
        else $error("queue reports full with no entry at its head");

    a_error_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status != STATUS_OK)) |-> (out_data.parsed_value == '0))
        else $error("error result carries a non-zero value");

    a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.status == STATUS_OK)
                       || (out_data.status == STATUS_NOT_CANONICAL)
                       || (out_data.status == STATUS_OUT_OF_RANGE)))
        else $error("result has an unused status code");

    a_pop_needs_entry : assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("back end took a word from an empty queue");

endmodule

`default_nettype wire

/* tb/decimal_parse_checker.sv */
module decimal_parse_checker
    import c2i_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_word_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_word_t out_data,
    output int        mismatches,
    output int        awaited,
    output int        seen_ok,
    output int        seen_not_canonical,
    output int        seen_out_of_range
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0] acc_mag;
    logic        acc_ovf;
    logic        acc_neg;
    logic [1:0]  acc_digits;
    logic        acc_lead_zero;
    logic        acc_fault;

    out_word_t awaited_results[$];
    out_word_t want;
    out_word_t verdict;

    task automatic clear_accumulator();
        acc_mag       = '0;
        acc_ovf       = 1'b0;
        acc_neg       = 1'b0;
        acc_digits    = 2'd0;
        acc_lead_zero = 1'b0;
        acc_fault     = 1'b0;
    endtask

    task automatic fold_character(input logic signed_mode, input logic [7:0] ch);
        logic        at_start;
        logic [63:0] d;
        logic [63:0] ceiling;
        at_start = (acc_digits == 2'd0) && !acc_neg && !acc_fault;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
        begin
            d = {56'd0, ch - CHAR_ZERO};
            if (acc_digits == 2'd0)
            begin
                if (d == 64'd0)
                    acc_lead_zero = 1'b1;
            end
            else if (acc_lead_zero)
            begin
                acc_fault = 1'b1;
            end
            if (acc_digits != 2'd3)
                acc_digits = acc_digits + 2'd1;
            ceiling = (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10;
            if (acc_mag > ceiling)
                acc_ovf = 1'b1;
            acc_mag = acc_mag * 64'd10 + d;
        end
        else if (ch == CHAR_MINUS && signed_mode && at_start)
        begin
            acc_neg = 1'b1;
        end
        else
        begin
            acc_fault = 1'b1;
        end
    endtask

    task automatic judge_string(input logic signed_mode, output out_word_t res);
        logic        bad;
        logic [63:0] bound;
        bad = acc_fault || acc_digits == 2'd0
            || (acc_neg && acc_lead_zero && acc_digits == 2'd1)
            || (acc_neg && !signed_mode);
        if (!signed_mode)
            bound = 64'hFFFF_FFFF_FFFF_FFFF;
        else if (acc_neg)
            bound = 64'h8000_0000_0000_0000;
        else
            bound = 64'h7FFF_FFFF_FFFF_FFFF;
        res.parsed_value = '0;
        if (bad)
        begin
            res.status = STATUS_NOT_CANONICAL;
        end
        else if (acc_ovf || acc_mag > bound)
        begin
            res.status = STATUS_OUT_OF_RANGE;
        end
        else
        begin
            res.status       = STATUS_OK;
            res.parsed_value = acc_neg ? -acc_mag : acc_mag;
        end
        clear_accumulator();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_accumulator();
            awaited_results.delete();
            mismatches         = 0;
            awaited            = 0;
            seen_ok            = 0;
            seen_not_canonical = 0;
            seen_out_of_range  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result word with nothing awaited, got value %h status %0d",
                             $time, out_data.parsed_value, out_data.status);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (out_data.parsed_value !== want.parsed_value)
                    begin
                        $display("%0t: parsed_value expected %h, got %h",
                                 $time, want.parsed_value, out_data.parsed_value);
                        mismatches++;
                    end
                    if (out_data.status !== want.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, out_data.status);
                        mismatches++;
                    end
                    case (want.status)
                        STATUS_OK:            seen_ok++;
                        STATUS_NOT_CANONICAL: seen_not_canonical++;
                        default:              seen_out_of_range++;
                    endcase
                end
            end
            if (in_valid && !in_stall)
            begin
                if (!in_data.no_char)
                    fold_character(in_data.func, in_data.character);
                if (in_data.last)
                begin
                    judge_string(in_data.func, verdict);
                    awaited_results = {awaited_results, verdict};
                end
            end
            awaited = awaited_results.size();
        end
    end

endmodule

/* tb/tb_canonical_decimal_to_int64_top.sv */
module tb_canonical_decimal_to_int64_top;
    timeunit 1ns;
    timeprecision 1ps;
    import c2i_pkg::*;

    localparam int unsigned ITEM_TARGET = 1500;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [7:0]  CHAR_PLUS   = 8'h2B;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_data;

    int mismatches;
    int awaited;
    int seen_ok;
    int seen_not_canonical;
    int seen_out_of_range;

    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned items_sent = 0;
    int unsigned words_sent = 0;
    int unsigned strings_sent = 0;
    int unsigned cycle_count = 0;

    logic [7:0] chars[$];

    canonical_decimal_to_int64_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    decimal_parse_checker results_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .in_data            (in_data),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .out_data           (out_data),
        .mismatches         (mismatches),
        .awaited            (awaited),
        .seen_ok            (seen_ok),
        .seen_not_canonical (seen_not_canonical),
        .seen_out_of_range  (seen_out_of_range)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic put_word(input in_word_t w);
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        if (!(w.no_char && !w.last))
            items_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            in_data  <= in_word_t'($urandom);
            repeat ($urandom_range(4, 1))
                @(posedge clk);
        end
    endtask

    task automatic load_text(input string s);
        chars.delete();
        for (int i = 0; i < s.len(); i++)
            chars = {chars, s[i]};
    endtask

    // The function bit flips from the character at flip_at onwards, an ignored
    // word is slipped in before the character at ghost_at, and close_empty ends
    // the string with a word that carries no character.
    task automatic send_chars(input logic mode, input int flip_at, input int ghost_at,
                              input bit close_empty);
        in_word_t w;
        int       n;
        n = chars.size();
        for (int i = 0; i < n; i++)
        begin
            if (i == ghost_at)
            begin
                w.func      = mode;
                w.character = 8'($urandom);
                w.no_char   = 1'b1;
                w.last      = 1'b0;
                put_word(w);
            end
            w.func      = (flip_at >= 0 && i >= flip_at) ? ~mode : mode;
            w.character = chars[i];
            w.no_char   = 1'b0;
            w.last      = (i == n - 1) && !close_empty;
            put_word(w);
        end
        if (close_empty || n == 0)
        begin
            w.func      = (flip_at >= 0) ? ~mode : mode;
            w.character = 8'($urandom);
            w.no_char   = 1'b1;
            w.last      = 1'b1;
            put_word(w);
        end
        strings_sent++;
    endtask

    task automatic send_random_string();
        logic        mode;
        logic [63:0] v;
        int          kind;
        int          flip_at;
        int          ghost_at;
        bit          close_empty;
        mode = 1'($urandom_range(1));
        kind = $urandom_range(99);
        if (kind < 85)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5:
                begin
                    v = {$urandom, $urandom} >> $urandom_range(63);
                    load_text($sformatf("%0d", v));
                end
                6, 7:
                begin
                    case ($urandom_range(3))
                        0:       v = 64'hFFFF_FFFF_FFFF_FFFF;
                        1:       v = 64'h7FFF_FFFF_FFFF_FFFF;
                        2:       v = 64'h8000_0000_0000_0000;
                        default: v = 64'd0;
                    endcase
                    v = v + 64'($urandom_range(4)) - 64'd2;
                    load_text($sformatf("%0d", v));
                end
                default:
                begin
                    chars.delete();
                    chars = {chars, CHAR_ZERO + 8'($urandom_range(9, 1))};
                    repeat ($urandom_range(21, 18))
                        chars = {chars, CHAR_ZERO + 8'($urandom_range(9))};
                end
            endcase
            if (mode && $urandom_range(1))
                chars.push_front(CHAR_MINUS);
            if (kind >= 70)
            begin
                case ($urandom_range(5))
                    0:
                    begin
                        v[31:0] = $urandom_range(chars.size());
                        if (v[31:0] == chars.size())
                            chars = {chars, 8'($urandom)};
                        else
                            chars.insert(v[31:0], 8'($urandom));
                    end
                    1:       chars.push_front(CHAR_ZERO);
                    2:       chars.push_front(CHAR_PLUS);
                    3:       chars.push_front(CHAR_MINUS);
                    4:       chars = {chars, CHAR_MINUS};
                    default: chars.delete();
                endcase
            end
        end
        else
        begin
            chars.delete();
            repeat ($urandom_range(6, 1))
                chars = {chars, 8'($urandom_range(255))};
        end
        flip_at     = ($urandom_range(19) == 0) ? $urandom_range(chars.size()) : -1;
        ghost_at    = ($urandom_range(9) == 0 && chars.size() > 0)
                    ? $urandom_range(chars.size() - 1) : -1;
        close_empty = ($urandom_range(9) == 0);
        send_chars(mode, flip_at, ghost_at, close_empty);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_stall <= 1'b0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_text("0");                        send_chars(1'b0, -1, -1, 1'b0);
        load_text("18446744073709551615");     send_chars(1'b0, -1, -1, 1'b0);
        load_text("18446744073709551616");     send_chars(1'b0, -1, -1, 1'b0);
        load_text("99999999999999999999999");  send_chars(1'b0, -1, -1, 1'b0);
        load_text("");                         send_chars(1'b0, -1, -1, 1'b0);
        load_text("");                         send_chars(1'b1, -1, -1, 1'b0);
        load_text("-5");                       send_chars(1'b0, -1, -1, 1'b0);
        load_text("+5");                       send_chars(1'b1, -1, -1, 1'b0);
        load_text("007");                      send_chars(1'b0, -1, -1, 1'b0);
        load_text("12a");                      send_chars(1'b0, -1, -1, 1'b0);
        load_text("9223372036854775807");      send_chars(1'b1, -1, -1, 1'b0);
        load_text("9223372036854775808");      send_chars(1'b1, -1, -1, 1'b0);
        load_text("-9223372036854775808");     send_chars(1'b1, -1, -1, 1'b0);
        load_text("-9223372036854775809");     send_chars(1'b1, -1, -1, 1'b0);
        load_text("-0");                       send_chars(1'b1, -1, -1, 1'b0);
        load_text("-");                        send_chars(1'b1, -1, -1, 1'b0);
        load_text("--1");                      send_chars(1'b1, -1, -1, 1'b0);
        load_text("1-");                       send_chars(1'b1, -1, -1, 1'b0);
        load_text("-01");                      send_chars(1'b1, -1, -1, 1'b0);
        load_text("0");                        send_chars(1'b1, -1, -1, 1'b0);
        load_text("000000000000000000000000001"); send_chars(1'b0, -1, -1, 1'b0);
        load_text("-5");                       send_chars(1'b1, 1, -1, 1'b0);
        load_text("19");                       send_chars(1'b0, 1, -1, 1'b0);
        load_text("42");                       send_chars(1'b0, -1, 1, 1'b0);
        load_text("-42");                      send_chars(1'b1, -1, -1, 1'b1);

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 68; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 68; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            while (items_sent < (p + 1) * ITEM_TARGET / 4)
                send_random_string();
        end

        in_valid <= 1'b0;
        @(negedge clk);
        while (awaited != 0)
            @(negedge clk);
        repeat (10)
            @(posedge clk);

        $display("Sent %0d words (%0d counted characters) forming %0d strings.",
                 words_sent, items_sent, strings_sent);
        $display("Results checked: %0d in range, %0d not canonical, %0d out of range.",
                 seen_ok, seen_not_canonical, seen_out_of_range);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
